/* sv/balance_robot_pd_controller_defines.svh */
// Assertion helpers shared by the controller RTL.
// Both forms are empty when SYNTHESIS is defined.
`ifndef BALANCE_ROBOT_PD_CONTROLLER_DEFINES_SVH
`define BALANCE_ROBOT_PD_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication: cons must hold whenever ante holds.
`define BRPD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define BRPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define BRPD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BRPD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/brpd_pkg.sv */
`timescale 1ns / 1ps

package brpd_pkg;

   // Field widths
   localparam int PITCH_W    = 17;
   localparam int ENC_W      = 16;
   localparam int GAIN_W     = 16;
   localparam int TRIM_W     = 15;
   localparam int OFFSET_W   = 10;
   localparam int MOTOR_W    = 9;

   // Port widths
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 24;

   // Datapath widths
   localparam int FRAC_W    = 8;
   localparam int FILT_W    = 25;
   localparam int ANGLE_W   = 18;
   localparam int RATE_W    = ANGLE_W + 1;
   localparam int SPEED_W   = 9;
   localparam int WRATE_W   = SPEED_W + 1;
   localparam int DIFF_W    = SPEED_W + 1;
   localparam int P_RATE_W  = RATE_W + GAIN_W + 1;
   localparam int P_ANGLE_W = ANGLE_W + GAIN_W + 1;
   localparam int P_WRATE_W = WRATE_W + GAIN_W + 1;
   localparam int P_WHEEL_W = SPEED_W + GAIN_W + 1;
   localparam int P_STEER_W = DIFF_W + GAIN_W + 1;
   localparam int SUM_W     = P_RATE_W + 4;
   localparam int TORQUE_W  = 16;
   localparam int DRIVE_W   = TORQUE_W + 1;

   // Controller constants
   localparam logic signed [ANGLE_W-1:0] TILT_LIMIT_Q8 = 18'sd11520;
   localparam int   MOTOR_MAX    = 255;
   localparam int   DEAD_BAND    = 20;
   localparam int   DRIVE_LIMIT  = 255;
   localparam int   TORQUE_MAX   = 32767;
   localparam int   TORQUE_MIN   = -32768;
   localparam logic INVERT_PITCH = 1'b0;

   // Divide by ten: multiply by ceil(2^30 / 10), exact for magnitudes below 2^27
   localparam int                  DIV10_W     = 27;
   localparam int                  DIV10_SHIFT = 30;
   localparam logic [DIV10_W-1:0]  DIV10_RECIP = 27'd107374183;

   // Register reset values
   localparam logic [GAIN_W-1:0]          GAIN_ANGLE_RATE_RST = 16'd7680;
   localparam logic [GAIN_W-1:0]          GAIN_ANGLE_RST      = 16'd8192;
   localparam logic [GAIN_W-1:0]          GAIN_WHEEL_RATE_RST = 16'd1664;
   localparam logic [GAIN_W-1:0]          GAIN_WHEEL_RST      = 16'd1331;
   localparam logic [GAIN_W-1:0]          GAIN_STEER_RST      = 16'd2048;
   localparam logic signed [TRIM_W-1:0]   PITCH_TRIM_RST      = '0;
   localparam logic signed [OFFSET_W-1:0] DRIVE_OFFSET_RST    = '0;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GAIN_ANGLE_RATE    = 3'd0,
      CSR_GAIN_ANGLE         = 3'd1,
      CSR_GAIN_WHEEL_RATE    = 3'd2,
      CSR_GAIN_WHEEL         = 3'd3,
      CSR_GAIN_STEER         = 3'd4,
      CSR_PITCH_TRIM         = 3'd5,
      CSR_DRIVE_OFFSET_LEFT  = 3'd6,
      CSR_DRIVE_OFFSET_RIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]          gain_angle_rate;
      logic [GAIN_W-1:0]          gain_angle;
      logic [GAIN_W-1:0]          gain_wheel_rate;
      logic [GAIN_W-1:0]          gain_wheel;
      logic [GAIN_W-1:0]          gain_steer;
      logic signed [TRIM_W-1:0]   pitch_trim;
      logic signed [OFFSET_W-1:0] drive_offset_left;
      logic signed [OFFSET_W-1:0] drive_offset_right;
   } cfg_type;

   typedef struct packed {
      logic signed [PITCH_W-1:0] pitch_raw;
      logic signed [ENC_W-1:0]   encoder_left;
      logic signed [ENC_W-1:0]   encoder_right;
      logic                      encoder_valid;
   } req_item_type;

   typedef struct packed {
      logic                      tilt;
      logic signed [ANGLE_W-1:0] angle;
      logic signed [RATE_W-1:0]  rate;
      logic signed [FILT_W-1:0]  filt_left;
      logic signed [FILT_W-1:0]  filt_right;
   } front_out_type;

   typedef struct packed {
      logic                        tilt;
      logic signed [P_RATE_W-1:0]  p_rate;
      logic signed [P_ANGLE_W-1:0] p_angle;
      logic signed [P_WRATE_W-1:0] p_wrate;
      logic signed [P_WHEEL_W-1:0] p_wheel;
      logic signed [P_STEER_W-1:0] p_steer;
   } mid_out_type;

   typedef struct packed {
      logic signed [MOTOR_W-1:0] motor_right;
      logic signed [MOTOR_W-1:0] motor_left;
   } cmd_type;

endpackage

/* sv/brpd_front.sv */
`timescale 1ns / 1ps
`include "balance_robot_pd_controller_defines.svh"

// Input register and tilt / encoder filter stage.
module brpd_front import brpd_pkg::*; #(
   parameter logic PITCH_INVERT = INVERT_PITCH
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  req_item_type  in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output front_out_type out_item
);

   logic                     s0_valid_ff, s0_valid_in;
   req_item_type             s0_ff;
   logic                     s1_valid_ff, s1_valid_in;
   front_out_type            s1_ff, s1_in;
   logic signed [FILT_W-1:0] filt_left_ff, filt_left_in;
   logic signed [FILT_W-1:0] filt_right_ff, filt_right_in;
   logic signed [ANGLE_W-1:0] prev_angle_ff, prev_angle_in;

   logic s0_move, s0_load, s1_ready, tilt, enc_update;
   logic signed [ANGLE_W-1:0] raw_ext, trim_ext, pitch_sum, pitch, angle;
   logic signed [RATE_W-1:0]  rate;

   // f' = (9 f + 256 count) / 10, truncated toward zero
   function automatic logic signed [FILT_W-1:0] filter_step(
      input logic signed [FILT_W-1:0] f,
      input logic signed [ENC_W-1:0]  count
   );
      logic signed [FILT_W+4:0]         f_ext;
      logic signed [FILT_W+4:0]         c_ext;
      logic signed [FILT_W+4:0]         num;
      logic [FILT_W+3:0]                mag;
      logic [FILT_W+DIV10_W+3:0]        prod;
      logic [FILT_W-1:0]                quo;
      f_ext = {{5{f[FILT_W-1]}}, f};
      c_ext = {{(FILT_W+5-ENC_W){count[ENC_W-1]}}, count};
      num   = (f_ext <<< 3) + f_ext + (c_ext <<< FRAC_W);
      mag   = num[FILT_W+4] ? (FILT_W+4)'(-num) : (FILT_W+4)'(num);
      prod  = (FILT_W+DIV10_W+4)'(mag) * (FILT_W+DIV10_W+4)'(DIV10_RECIP);
      quo   = prod[DIV10_SHIFT +: FILT_W];
      filter_step = num[FILT_W+4] ? -$signed(quo) : $signed(quo);
   endfunction

   // Handshake
   always_comb begin
      s1_ready    = !s1_valid_ff || out_ready;
      s0_move     = s0_valid_ff && s1_ready;
      in_ready    = !s0_valid_ff || s0_move;
      s0_load     = in_valid && in_ready;
      s0_valid_in = s0_load || (s0_valid_ff && !s0_move);
      s1_valid_in = s0_move || (s1_valid_ff && !out_ready);
   end

   // Pitch, tilt check, angle rate and filter update
   always_comb begin
      raw_ext   = {{(ANGLE_W-PITCH_W){s0_ff.pitch_raw[PITCH_W-1]}}, s0_ff.pitch_raw};
      trim_ext  = {{(ANGLE_W-TRIM_W){cfg.pitch_trim[TRIM_W-1]}}, cfg.pitch_trim};
      pitch_sum = raw_ext + trim_ext;
      pitch     = PITCH_INVERT ? -pitch_sum : pitch_sum;
      tilt      = (pitch > TILT_LIMIT_Q8) || (pitch < -TILT_LIMIT_Q8);
      angle     = pitch - trim_ext;
      rate      = {angle[ANGLE_W-1], angle} - {prev_angle_ff[ANGLE_W-1], prev_angle_ff};

      enc_update    = s0_move && !tilt && s0_ff.encoder_valid;
      filt_left_in  = enc_update ? filter_step(filt_left_ff, s0_ff.encoder_left)
                                 : filt_left_ff;
      filt_right_in = enc_update ? filter_step(filt_right_ff, s0_ff.encoder_right)
                                 : filt_right_ff;
      prev_angle_in = (s0_move && !tilt) ? angle : prev_angle_ff;

      s1_in.tilt       = tilt;
      s1_in.angle      = angle;
      s1_in.rate       = rate;
      s1_in.filt_left  = filt_left_in;
      s1_in.filt_right = filt_right_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         filt_left_ff  <= '0;
         filt_right_ff <= '0;
         prev_angle_ff <= '0;
      end else begin
         s0_valid_ff   <= s0_valid_in;
         s1_valid_ff   <= s1_valid_in;
         filt_left_ff  <= filt_left_in;
         filt_right_ff <= filt_right_in;
         prev_angle_ff <= prev_angle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_load) begin
         s0_ff <= in_item;
      end
      if (s0_move) begin
         s1_ff <= s1_in;
      end
   end

   assign out_valid = s1_valid_ff;
   assign out_item  = s1_ff;

   `BRPD_ASSERT_NEXT(a_left_filter_hold, clock, reset, !s0_move, $stable(filt_left_ff))
   `BRPD_ASSERT_NEXT(a_right_filter_hold, clock, reset, !s0_move, $stable(filt_right_ff))
   `BRPD_ASSERT_NEXT(a_tilt_keeps_angle, clock, reset, s0_move && tilt, $stable(prev_angle_ff))

endmodule

/* sv/brpd_gain.sv */
`timescale 1ns / 1ps

// Wheel speed stage and gain products.
module brpd_gain import brpd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  front_out_type in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output mid_out_type   out_item
);

   typedef struct packed {
      logic                      tilt;
      logic signed [ANGLE_W-1:0] angle;
      logic signed [RATE_W-1:0]  rate;
      logic signed [SPEED_W-1:0] wheel;
      logic signed [WRATE_W-1:0] wrate;
      logic signed [DIFF_W-1:0]  diff;
   } speed_stage_type;

   logic            s2_valid_ff, s2_valid_in, s3_valid_ff, s3_valid_in;
   speed_stage_type s2_ff, s2_in;
   mid_out_type     s3_ff, s3_in;
   logic signed [SPEED_W-1:0] prev_wheel_ff, prev_wheel_in;

   logic in_move, s2_move, s2_ready, s3_ready;
   logic signed [SPEED_W-1:0] speed_left, speed_right, wheel;
   logic signed [SPEED_W:0]   wheel_sum, wheel_half;

   // Q17.8 to integer speed, truncated toward zero and clamped
   function automatic logic signed [SPEED_W-1:0] to_speed(
      input logic signed [FILT_W-1:0] x
   );
      logic signed [FILT_W-1:0] q;
      q = x[FILT_W-1] ? ((x + FILT_W'((1 << FRAC_W) - 1)) >>> FRAC_W) : (x >>> FRAC_W);
      if (q > FILT_W'(MOTOR_MAX)) begin
         to_speed = SPEED_W'(MOTOR_MAX);
      end else if (q < -FILT_W'(MOTOR_MAX)) begin
         to_speed = -SPEED_W'(MOTOR_MAX);
      end else begin
         to_speed = SPEED_W'(q);
      end
   endfunction

   always_comb begin
      s3_ready    = !s3_valid_ff || out_ready;
      s2_move     = s2_valid_ff && s3_ready;
      s2_ready    = !s2_valid_ff || s2_move;
      in_ready    = s2_ready;
      in_move     = in_valid && s2_ready;
      s2_valid_in = in_move || (s2_valid_ff && !s2_move);
      s3_valid_in = s2_move || (s3_valid_ff && !out_ready);
   end

   // Speeds, mean wheel speed and its change
   always_comb begin
      speed_left  = to_speed(-$signed(in_item.filt_left));
      speed_right = to_speed($signed(in_item.filt_right));
      wheel_sum   = {speed_left[SPEED_W-1], speed_left}
                  + {speed_right[SPEED_W-1], speed_right};
      wheel_half  = wheel_sum[SPEED_W] ? ((wheel_sum + (SPEED_W+1)'(1)) >>> 1)
                                       : (wheel_sum >>> 1);
      wheel       = SPEED_W'(wheel_half);

      prev_wheel_in = (in_move && !in_item.tilt) ? wheel : prev_wheel_ff;

      s2_in.tilt  = in_item.tilt;
      s2_in.angle = in_item.angle;
      s2_in.rate  = in_item.rate;
      s2_in.wheel = wheel;
      s2_in.wrate = {wheel[SPEED_W-1], wheel} - {prev_wheel_ff[SPEED_W-1], prev_wheel_ff};
      s2_in.diff  = {speed_left[SPEED_W-1], speed_left}
                  - {speed_right[SPEED_W-1], speed_right};
   end

   // One multiplier per term, gains are unsigned
   always_comb begin
      s3_in.tilt    = s2_ff.tilt;
      s3_in.p_rate  = $signed(s2_ff.rate)  * $signed({1'b0, cfg.gain_angle_rate});
      s3_in.p_angle = $signed(s2_ff.angle) * $signed({1'b0, cfg.gain_angle});
      s3_in.p_wrate = $signed(s2_ff.wrate) * $signed({1'b0, cfg.gain_wheel_rate});
      s3_in.p_wheel = $signed(s2_ff.wheel) * $signed({1'b0, cfg.gain_wheel});
      s3_in.p_steer = $signed(s2_ff.diff)  * $signed({1'b0, cfg.gain_steer});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         prev_wheel_ff <= '0;
      end else begin
         s2_valid_ff   <= s2_valid_in;
         s3_valid_ff   <= s3_valid_in;
         prev_wheel_ff <= prev_wheel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         s2_ff <= s2_in;
      end
      if (s2_move) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_ff;

endmodule

/* sv/brpd_drive.sv */
`timescale 1ns / 1ps
`include "balance_robot_pd_controller_defines.svh"

// Torque sum, drive shaping and change-only output register.
module brpd_drive import brpd_pkg::*; #(
   parameter int DEAD_ZONE   = DEAD_BAND,
   parameter int DRIVE_CLAMP = DRIVE_LIMIT
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   output logic        in_ready,
   input  mid_out_type in_item,
   output logic        out_valid,
   input  logic        out_ready,
   output cmd_type     out_cmd
);

   localparam logic signed [MOTOR_W-1:0] DB = MOTOR_W'(DEAD_ZONE);

   typedef struct packed {
      logic                       tilt;
      logic signed [TORQUE_W-1:0] torque;
      logic signed [TORQUE_W-1:0] steer;
   } torque_stage_type;

   logic             s4_valid_ff, s4_valid_in, s5_valid_ff, s5_valid_in;
   torque_stage_type s4_ff, s4_in;
   cmd_type          s5_ff, s5_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cmd_type          rsp_ff;
   cmd_type          last_cmd_ff, last_cmd_in;

   logic in_move, s4_move, s4_ready, s5_move, s5_ready, slot_ready, changed;
   logic signed [SUM_W-1:0]     sum, torque_q;
   logic signed [P_STEER_W-1:0] steer_q;
   logic signed [DRIVE_W-1:0]   torque_x, steer_x;

   function automatic logic signed [DRIVE_W-1:0] clamp_drive(
      input logic signed [DRIVE_W-1:0] v
   );
      if (v > DRIVE_W'(DRIVE_CLAMP)) begin
         clamp_drive = DRIVE_W'(DRIVE_CLAMP);
      end else if (v < -DRIVE_W'(DRIVE_CLAMP)) begin
         clamp_drive = -DRIVE_W'(DRIVE_CLAMP);
      end else begin
         clamp_drive = v;
      end
   endfunction

   // Add the offset, clamp to the motor range, drop small commands
   function automatic logic signed [MOTOR_W-1:0] to_motor(
      input logic signed [DRIVE_W-1:0]  v,
      input logic signed [OFFSET_W-1:0] off
   );
      logic signed [DRIVE_W:0]  s;
      logic signed [MOTOR_W-1:0] m;
      s = {v[DRIVE_W-1], v} + {{(DRIVE_W+1-OFFSET_W){off[OFFSET_W-1]}}, off};
      if (s > (DRIVE_W+1)'(MOTOR_MAX)) begin
         m = MOTOR_W'(MOTOR_MAX);
      end else if (s < -(DRIVE_W+1)'(MOTOR_MAX)) begin
         m = -MOTOR_W'(MOTOR_MAX);
      end else begin
         m = MOTOR_W'(s);
      end
      if ((m > 0 && m < DB) || (m < 0 && m > -DB)) begin
         m = '0;
      end
      to_motor = m;
   endfunction

   // True when a command is zero or outside the dead band
   function automatic logic band_ok(input logic signed [MOTOR_W-1:0] m);
      band_ok = (m == 0) || (m >= DB) || (m <= -DB);
   endfunction

   always_comb begin
      slot_ready   = !rsp_valid_ff || out_ready;
      s5_move      = s5_valid_ff && slot_ready;
      s5_ready     = !s5_valid_ff || s5_move;
      s4_move      = s4_valid_ff && s5_ready;
      s4_ready     = !s4_valid_ff || s4_move;
      in_ready     = s4_ready;
      in_move      = in_valid && s4_ready;
      s4_valid_in  = in_move || (s4_valid_ff && !s4_move);
      s5_valid_in  = s4_move || (s5_valid_ff && !s5_move);
   end

   // Torque and steering terms, truncated toward zero and saturated
   always_comb begin
      sum = SUM_W'($signed(in_item.p_rate)) + SUM_W'($signed(in_item.p_angle))
          + ((SUM_W'($signed(in_item.p_wrate)) + SUM_W'($signed(in_item.p_wheel)))
             <<< FRAC_W);
      torque_q = sum[SUM_W-1]
               ? ((sum + SUM_W'((1 << (2*FRAC_W)) - 1)) >>> (2*FRAC_W))
               : (sum >>> (2*FRAC_W));
      steer_q  = in_item.p_steer[P_STEER_W-1]
               ? (($signed(in_item.p_steer) + P_STEER_W'((1 << FRAC_W) - 1)) >>> FRAC_W)
               : ($signed(in_item.p_steer) >>> FRAC_W);

      s4_in.tilt = in_item.tilt;
      if (torque_q > SUM_W'(TORQUE_MAX)) begin
         s4_in.torque = TORQUE_W'(TORQUE_MAX);
      end else if (torque_q < SUM_W'(TORQUE_MIN)) begin
         s4_in.torque = TORQUE_W'(TORQUE_MIN);
      end else begin
         s4_in.torque = TORQUE_W'(torque_q);
      end
      if (steer_q > P_STEER_W'(TORQUE_MAX)) begin
         s4_in.steer = TORQUE_W'(TORQUE_MAX);
      end else if (steer_q < P_STEER_W'(TORQUE_MIN)) begin
         s4_in.steer = TORQUE_W'(TORQUE_MIN);
      end else begin
         s4_in.steer = TORQUE_W'(steer_q);
      end
   end

   // Motor commands; a tilted item forces a stop
   always_comb begin
      torque_x = {s4_ff.torque[TORQUE_W-1], s4_ff.torque};
      steer_x  = {s4_ff.steer[TORQUE_W-1], s4_ff.steer};
      if (s4_ff.tilt) begin
         s5_in = '0;
      end else begin
         s5_in.motor_left  = to_motor(clamp_drive(torque_x - steer_x),
                                      cfg.drive_offset_left);
         s5_in.motor_right = to_motor(clamp_drive(torque_x), cfg.drive_offset_right);
      end
   end

   // Pass a command on only when it differs from the last one
   always_comb begin
      changed      = (s5_ff != last_cmd_ff);
      rsp_valid_in = s5_move ? changed : (rsp_valid_ff && !out_ready);
      last_cmd_in  = (s5_move && changed) ? s5_ff : last_cmd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_cmd_ff  <= '0;
      end else begin
         s4_valid_ff  <= s4_valid_in;
         s5_valid_ff  <= s5_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         last_cmd_ff  <= last_cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         s4_ff <= s4_in;
      end
      if (s4_move) begin
         s5_ff <= s5_in;
      end
      if (s5_move && changed) begin
         rsp_ff <= s5_ff;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_cmd   = rsp_ff;

   `BRPD_ASSERT_NEXT(a_rsp_needs_item, clock, reset, !rsp_valid_ff && !s5_move, !rsp_valid_ff)
   `BRPD_ASSERT_IMPL(a_rsp_is_last, clock, reset, rsp_valid_ff, rsp_ff == last_cmd_ff)
   `BRPD_ASSERT_IMPL(a_left_dead_zone, clock, reset, rsp_valid_ff, band_ok(rsp_ff.motor_left))
   `BRPD_ASSERT_IMPL(a_right_dead_zone, clock, reset, rsp_valid_ff, band_ok(rsp_ff.motor_right))

endmodule

/* sv/balance_robot_pd_controller.sv */
// Self-balancing two-wheel PD controller. Each req transfer is one control
// tick: a Q9.8 pitch sample plus left/right encoder speed counts and an
// encoder-valid flag. A pitch (after trim) beyond 45 degrees commands a stop
// and leaves all filter and angle/wheel history untouched; otherwise the
// encoder speeds run through a 0.9/0.1 low-pass, and a torque is built from
// tilt angle, angle rate, mean wheel speed and its rate, with a steering
// correction on the left motor. Commands are clamped, offset, clamped again
// and dead-zoned, and a rsp transfer is produced only when the command pair
// changes, so a tick may yield no result. The block takes one tick per clock
// cycle when rsp_tready stays high; a result passes through s0 to s5 and
// the output register before rsp_tvalid. Throughput is set by the encoder
// filter loop, which closes through the divide-by-ten multiplier. Gains
// and offsets are to be written by the user through the csr port while
// no tick is in flight; the block does not enforce this. They take effect
// on the next tick. DEAD_ZONE sets the dead band, PITCH_INVERT flips the
// pitch sign and DRIVE_CLAMP limits the drive before the offsets are added.
`timescale 1ns / 1ps

module balance_robot_pd_controller import brpd_pkg::*; #(
   parameter int   DEAD_ZONE    = DEAD_BAND,
   parameter logic PITCH_INVERT = INVERT_PITCH,
   parameter int   DRIVE_CLAMP  = DRIVE_LIMIT
) (
   input  logic                   clock,
   input  logic                   reset,

   // Tick input
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [16:0] pitch_raw, [32:17] encoder_left, [48:33] encoder_right, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] encoder_valid
   input  logic [REQ_TUSER_W-1:0] req_tuser,

   // Motor command output
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [8:0] motor_left, [17:9] motor_right, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,

   // Register writes
   input  logic                   csr_wr_en,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   req_item_type  req_item;
   front_out_type front_item;
   mid_out_type   mid_item;
   cmd_type       rsp_cmd;
   logic          front_valid, front_ready, mid_valid, mid_ready;

   // Register file: truncate the write data to each register's width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_addr))
            CSR_GAIN_ANGLE_RATE:    cfg_in.gain_angle_rate    = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_ANGLE:         cfg_in.gain_angle         = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_WHEEL_RATE:    cfg_in.gain_wheel_rate    = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_WHEEL:         cfg_in.gain_wheel         = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_STEER:         cfg_in.gain_steer         = csr_wdata[GAIN_W-1:0];
            CSR_PITCH_TRIM:         cfg_in.pitch_trim         = csr_wdata[TRIM_W-1:0];
            CSR_DRIVE_OFFSET_LEFT:  cfg_in.drive_offset_left  = csr_wdata[OFFSET_W-1:0];
            CSR_DRIVE_OFFSET_RIGHT: cfg_in.drive_offset_right = csr_wdata[OFFSET_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_angle_rate    <= GAIN_ANGLE_RATE_RST;
         cfg_ff.gain_angle         <= GAIN_ANGLE_RST;
         cfg_ff.gain_wheel_rate    <= GAIN_WHEEL_RATE_RST;
         cfg_ff.gain_wheel         <= GAIN_WHEEL_RST;
         cfg_ff.gain_steer         <= GAIN_STEER_RST;
         cfg_ff.pitch_trim         <= PITCH_TRIM_RST;
         cfg_ff.drive_offset_left  <= DRIVE_OFFSET_RST;
         cfg_ff.drive_offset_right <= DRIVE_OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Unpack the tick; the top pad bits of tdata are ignored
   always_comb begin
      req_item.pitch_raw     = req_tdata[PITCH_W-1:0];
      req_item.encoder_left  = req_tdata[PITCH_W +: ENC_W];
      req_item.encoder_right = req_tdata[PITCH_W+ENC_W +: ENC_W];
      req_item.encoder_valid = req_tuser[0];
   end

   // Input register, tilt check, encoder filter, angle rate
   brpd_front #(
      .PITCH_INVERT (PITCH_INVERT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   // Wheel speeds and the five gain products
   brpd_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_item  (mid_item)
   );

   // Torque sum, motor shaping, change detection and output register
   brpd_drive #(
      .DEAD_ZONE   (DEAD_ZONE),
      .DRIVE_CLAMP (DRIVE_CLAMP)
   ) u_drive (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_item   (mid_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_cmd   (rsp_cmd)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-2*MOTOR_W){1'b0}}, rsp_cmd.motor_right,
                       rsp_cmd.motor_left};

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import brpd_pkg::*;

   localparam int TICKS_PER_PHASE = 60;
   localparam int RANDOM_PHASES   = 9;
   localparam int HOLD_PHASE      = 4;     // phase with the long receiver hold-off
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 16;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int REPORT_LIMIT    = 10;
   localparam int TIMEOUT_NS      = 2_000_000;

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_GAPS,
      FLOW_RECEIVER_STALLS,
      FLOW_BOTH
   } flow_mode_type;

   // One directed tick; when known is set, the row carries its own expectation.
   typedef struct packed {
      logic signed [PITCH_W-1:0] pitch;
      logic signed [ENC_W-1:0]   enc_left;
      logic signed [ENC_W-1:0]   enc_right;
      logic                      enc_valid;
      logic                      known;
      logic                      yields;
      logic signed [MOTOR_W-1:0] left;
      logic signed [MOTOR_W-1:0] right;
   } tick_row_type;

   localparam logic KNOWN = 1'b1;
   localparam logic PRED  = 1'b0;

   localparam cfg_type RESET_GAINS = '{
      GAIN_ANGLE_RATE_RST, GAIN_ANGLE_RST, GAIN_WHEEL_RATE_RST, GAIN_WHEEL_RST,
      GAIN_STEER_RST, PITCH_TRIM_RST, DRIVE_OFFSET_RST, DRIVE_OFFSET_RST};

   // Directed ticks, run with the reset register values and zero state.
   localparam int DIRECTED_ROWS = 15;
   localparam tick_row_type DIRECTED_TICKS [DIRECTED_ROWS] = '{
      // level and still: command stays at zero, no transfer
      '{0,      0,      0,      1, KNOWN, 0, 0,    0},
      // just past 45 degrees either way: stop command equals the last one
      '{11521,  0,      0,      1, KNOWN, 0, 0,    0},
      '{-11521, 0,      0,      1, KNOWN, 0, 0,    0},
      // exactly 45 degrees is still controlled; the drive saturates forward
      '{11520,  0,      0,      0, KNOWN, 1, 255,  255},
      // far over: stop issued
      '{46080,  0,      0,      1, KNOWN, 1, 0,    0},
      '{-46080, 0,      0,      0, KNOWN, 0, 0,    0},
      // back limit after the forward one: the drive saturates backward
      '{-11520, 0,      0,      0, KNOWN, 1, -255, -255},
      // encoder extremes, steering both ways
      '{0,      32767,  -32768, 1, PRED,  0, 0,    0},
      '{0,      -32768, 32767,  1, PRED,  0, 0,    0},
      // stale encoder sample: speeds hold
      '{0,      32767,  32767,  0, PRED,  0, 0,    0},
      '{0,      0,      0,      1, PRED,  0, 0,    0},
      // small commands around the dead band
      '{64,     5,      5,      1, PRED,  0, 0,    0},
      '{-64,    -5,     -5,     1, PRED,  0, 0,    0},
      '{0,      0,      0,      1, PRED,  0, 0,    0},
      '{0,      0,      0,      1, PRED,  0, 0,    0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // [16:0] pitch_raw, [32:17] encoder_left,
                                             // [48:33] encoder_right, zero pad
   logic [REQ_TUSER_W-1:0] req_tuser = '0;   // [0] encoder_valid
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // [8:0] motor_left, [17:9] motor_right, zero pad
   logic                   csr_wr_en = 1'b0;
   csr_index_type          csr_addr = CSR_GAIN_ANGLE_RATE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   balance_robot_pd_controller uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Controller copy: registers as last written, plus filter and command state.
   cfg_type gains = RESET_GAINS;
   longint  lp_left = 0, lp_right = 0;
   longint  spd_left = 0, spd_right = 0;
   longint  held_angle = 0, held_wheel = 0;
   longint  cmd_left = 0, cmd_right = 0;

   cmd_type pending_commands [$];
   int      mismatch_count = 0;

   // Flow control; the stall and hold-off settings are shared with the receiver process.
   int      gap_pct = 0;
   int      stall_pct = 0;
   int      hold_requests = 0;
   int      holds_served = 0;
   int      hold_left = 0;

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Clamp, dead-zone and compare with the last command; return 1 on a change.
   function automatic bit settle_command(input longint left, input longint right,
                                         output cmd_type cmd);
      longint l, r;
      l = clamp(left, -MOTOR_MAX, MOTOR_MAX);
      r = clamp(right, -MOTOR_MAX, MOTOR_MAX);
      if (l != 0 && l < DEAD_BAND && l > -DEAD_BAND) l = 0;
      if (r != 0 && r < DEAD_BAND && r > -DEAD_BAND) r = 0;
      cmd.motor_left  = MOTOR_W'(l);
      cmd.motor_right = MOTOR_W'(r);
      if (l == cmd_left && r == cmd_right) return 1'b0;
      cmd_left  = l;
      cmd_right = r;
      return 1'b1;
   endfunction

   // Advance the controller copy by one tick; return 1 when a command goes out.
   function automatic bit step_controller(input req_item_type t, output cmd_type cmd);
      longint pitch, angle, rate, wheel, wheel_rate, torque, steer;
      longint trim;
      trim  = longint'(gains.pitch_trim);
      pitch = longint'(t.pitch_raw) + trim;
      if (INVERT_PITCH) pitch = -pitch;
      if (pitch > longint'(TILT_LIMIT_Q8) || pitch < -longint'(TILT_LIMIT_Q8))
         return settle_command(0, 0, cmd);

      if (t.encoder_valid) begin
         lp_left   = (9 * lp_left + 256 * longint'(t.encoder_left)) / 10;
         lp_right  = (9 * lp_right + 256 * longint'(t.encoder_right)) / 10;
         spd_left  = clamp((-lp_left) / 256, -MOTOR_MAX, MOTOR_MAX);
         spd_right = clamp(lp_right / 256, -MOTOR_MAX, MOTOR_MAX);
      end

      angle      = pitch - trim;
      rate       = angle - held_angle;
      held_angle = angle;
      wheel      = (spd_left + spd_right) / 2;
      wheel_rate = wheel - held_wheel;
      held_wheel = wheel;

      torque = (rate * longint'(gains.gain_angle_rate) + angle * longint'(gains.gain_angle)
                + 256 * (wheel_rate * longint'(gains.gain_wheel_rate)
                         + wheel * longint'(gains.gain_wheel))) / 65536;
      torque = clamp(torque, TORQUE_MIN, TORQUE_MAX);
      steer  = clamp((longint'(gains.gain_steer) * (spd_left - spd_right)) / 256,
                     TORQUE_MIN, TORQUE_MAX);

      return settle_command(
         clamp(torque - steer, -DRIVE_LIMIT, DRIVE_LIMIT) + longint'(gains.drive_offset_left),
         clamp(torque, -DRIVE_LIMIT, DRIVE_LIMIT) + longint'(gains.drive_offset_right),
         cmd);
   endfunction

   function automatic void flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
   endfunction

   // Offer one tick after any random sender gaps, hold it until the transfer, then predict its command.
   task automatic offer_tick(input req_item_type t, output bit fired, output cmd_type cmd);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({t.encoder_right, t.encoder_left, t.pitch_raw});
      req_tuser  <= t.encoder_valid;
      do @(posedge clock); while (!req_tready);
      fired = step_controller(t, cmd);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Wait for every expected command, then let ticks without a result drain.
   task automatic wait_until_idle();
      int waited;
      waited = 0;
      while (pending_commands.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Receiver: random stalls per flow mode, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Check every command transfer against the oldest expectation.
   always @(posedge clock) begin : check_commands
      cmd_type want;
      cmd_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.motor_left  = rsp_tdata[MOTOR_W-1:0];
         got.motor_right = rsp_tdata[2*MOTOR_W-1:MOTOR_W];
         if (pending_commands.size() == 0) begin
            flag_error($sformatf("unexpected command left=%0d right=%0d",
                                 got.motor_left, got.motor_right));
         end else begin
            want = pending_commands.pop_front();
            if (got.motor_left !== want.motor_left || got.motor_right !== want.motor_right)
               flag_error($sformatf(
                  "command mismatch: expected left=%0d right=%0d, got left=%0d right=%0d",
                  want.motor_left, want.motor_right, got.motor_left, got.motor_right));
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      req_item_type t;
      req_item_type last_tick;
      cmd_type      cmd;
      cfg_type      next_gains;
      bit           fired;
      int           pitch_walk;
      int           roll;
      int           p;
      int           n;

      pitch_walk = 0;
      last_tick  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part on reset registers; typed rows override the prediction.
      for (n = 0; n < DIRECTED_ROWS; n++) begin
         t.pitch_raw     = DIRECTED_TICKS[n].pitch;
         t.encoder_left  = DIRECTED_TICKS[n].enc_left;
         t.encoder_right = DIRECTED_TICKS[n].enc_right;
         t.encoder_valid = DIRECTED_TICKS[n].enc_valid;
         offer_tick(t, fired, cmd);
         if (DIRECTED_TICKS[n].known) begin
            fired           = DIRECTED_TICKS[n].yields;
            cmd.motor_left  = DIRECTED_TICKS[n].left;
            cmd.motor_right = DIRECTED_TICKS[n].right;
         end
         if (fired) pending_commands.push_back(cmd);
         last_tick = t;
      end

      for (p = 1; p <= RANDOM_PHASES; p++) begin
         // Drop valid and let the block go idle before touching registers.
         req_tvalid <= 1'b0;
         wait_until_idle();

         case (p)
            1: begin
               next_gains = RESET_GAINS;
               next_gains.drive_offset_left  = OFFSET_W'(int'($urandom_range(60)) - 30);
               next_gains.drive_offset_right = OFFSET_W'(int'($urandom_range(60)) - 30);
            end
            2: begin
               // zero gains: the command is the offsets alone, pinned at the limits
               next_gains = '0;
               next_gains.drive_offset_left  = OFFSET_W'(510);
               next_gains.drive_offset_right = OFFSET_W'(-510);
            end
            3: begin
               next_gains = '1;
               next_gains.pitch_trim         = TRIM_W'(11520);
               next_gains.drive_offset_left  = OFFSET_W'(-510);
               next_gains.drive_offset_right = OFFSET_W'(510);
            end
            HOLD_PHASE: begin
               next_gains = RESET_GAINS;
               next_gains.pitch_trim = TRIM_W'(-11520);
            end
            default: begin
               next_gains.gain_angle_rate    = GAIN_W'($urandom_range(16384));
               next_gains.gain_angle         = GAIN_W'($urandom_range(16384));
               next_gains.gain_wheel_rate    = GAIN_W'($urandom_range(4096));
               next_gains.gain_wheel         = GAIN_W'($urandom_range(4096));
               next_gains.gain_steer         = GAIN_W'($urandom());
               next_gains.pitch_trim         = TRIM_W'(int'($urandom_range(23040)) - 11520);
               next_gains.drive_offset_left  = OFFSET_W'(int'($urandom_range(200)) - 100);
               next_gains.drive_offset_right = OFFSET_W'(int'($urandom_range(200)) - 100);
            end
         endcase

         write_reg(CSR_GAIN_ANGLE_RATE,    next_gains.gain_angle_rate);
         write_reg(CSR_GAIN_ANGLE,         next_gains.gain_angle);
         write_reg(CSR_GAIN_WHEEL_RATE,    next_gains.gain_wheel_rate);
         write_reg(CSR_GAIN_WHEEL,         next_gains.gain_wheel);
         write_reg(CSR_GAIN_STEER,         next_gains.gain_steer);
         write_reg(CSR_PITCH_TRIM,         next_gains.pitch_trim);
         write_reg(CSR_DRIVE_OFFSET_LEFT,  next_gains.drive_offset_left);
         write_reg(CSR_DRIVE_OFFSET_RIGHT, next_gains.drive_offset_right);
         csr_wr_en <= 1'b0;
         gains = next_gains;

         case (flow_mode_type'(p % 4))
            FLOW_SENDER_GAPS:     begin gap_pct = 46; stall_pct <= 0;  end
            FLOW_RECEIVER_STALLS: begin gap_pct = 0;  stall_pct <= 46; end
            FLOW_BOTH:            begin gap_pct = 12; stall_pct <= 12; end
            default:              begin gap_pct = 0;  stall_pct <= 0;  end
         endcase

         for (n = 0; n < TICKS_PER_PHASE; n++) begin
            if (p == HOLD_PHASE && n == 10) begin
               // long receiver hold-off while ticks keep coming: fill the block up
               hold_requests <= hold_requests + 1;
            end
            if (p == HOLD_PHASE && n == 40) begin
               // pause the sender until every pending command has come out
               req_tvalid <= 1'b0;
               wait_until_idle();
            end

            // Mostly a near-balanced ride: pitch walks slowly around the trim point.
            pitch_walk = pitch_walk + int'($urandom_range(400)) - 200;
            if (pitch_walk > 3000) pitch_walk = 3000;
            if (pitch_walk < -3000) pitch_walk = -3000;
            roll = $urandom_range(99);
            if (roll >= 94) begin
               t = last_tick;
            end else begin
               if (roll < 8)
                  t.pitch_raw = PITCH_W'(int'($urandom_range(92160)) - 46080);
               else
                  t.pitch_raw = PITCH_W'(pitch_walk - int'(gains.pitch_trim));
               if ($urandom_range(9) == 0) begin
                  t.encoder_left  = ENC_W'($urandom());
                  t.encoder_right = ENC_W'($urandom());
               end else begin
                  t.encoder_left  = ENC_W'(int'($urandom_range(800)) - 400);
                  t.encoder_right = ENC_W'(int'($urandom_range(800)) - 400);
               end
               t.encoder_valid = ($urandom_range(99) < 80);
            end

            offer_tick(t, fired, cmd);
            if (fired) pending_commands.push_back(cmd);
            last_tick = t;
         end
      end

      req_tvalid <= 1'b0;
      wait_until_idle();
      if (pending_commands.size() != 0)
         flag_error($sformatf("%0d expected commands never arrived", pending_commands.size()));

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
